FILE: sv/mmw_pkg.sv
// Shared widths, register codes and the stage flag struct for the mecanum mixer.
// No dependencies.
package mmw_pkg;

   localparam int VEL_W      = 16;
   localparam int CLAMP_W    = VEL_W + 1;
   localparam int RPM_W      = 14;
   localparam int WDOG_W     = 16;
   localparam int SPEED_W    = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_RPM    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WDOG_LIMIT = 1'd1;

   localparam logic [RPM_W-1:0]  MAX_RPM_RESET    = 14'd960;
   localparam logic [WDOG_W-1:0] WDOG_LIMIT_RESET = 16'd500;

   localparam logic [WDOG_W-1:0] IDLE_SAT = {WDOG_W{1'b1}};

   typedef struct packed {
      logic zero_out;
      logic timed_out;
   } mmw_flags_type;

endpackage

FILE: sv/mecanum_mixer_with_watchdog.sv
// Mecanum wheel mixer with manual-mode command watchdog: top level.
// Throughput one word per cycle while rsp_ready stays high; each word passes stage 1, then the rsp register.
// Stage 1 updates held commands and watchdog and forms the mixing sums; stage 2
// multiplies by max_rpm, rounds and clamps into the rsp register.
// Synchronous reset clears held commands, idle count, trip flag, valids and
// loads max_rpm = 960 and watchdog_limit = 500. Depends on mmw_pkg, mmw_state, mmw_wheel.
module mecanum_mixer_with_watchdog import mmw_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic signed [VEL_W-1:0]     req_vel_forward,
   input  logic signed [VEL_W-1:0]     req_vel_strafe,
   input  logic signed [VEL_W-1:0]     req_vel_rotate,
   input  logic                        req_system_ready,
   input  logic                        req_manual_mode,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SPEED_W-1:0]   rsp_front_left_speed,
   output logic signed [SPEED_W-1:0]   rsp_front_right_speed,
   output logic signed [SPEED_W-1:0]   rsp_rear_left_speed,
   output logic signed [SPEED_W-1:0]   rsp_rear_right_speed,
   output logic                        rsp_timed_out,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SW = FRAC_BITS + 3;

   logic [RPM_W-1:0]  max_rpm_ff;
   logic [WDOG_W-1:0] wdog_limit_ff;

   logic req_fire;
   logic s1_valid_ff, s1_valid_in;
   logic s2_load;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [SW-1:0] sum_fl, sum_fr, sum_rl, sum_rr;
   mmw_flags_type        s1_flags;
   logic signed [SPEED_W-1:0] fl, fr, rl, rr;
   logic signed [SPEED_W-1:0] fl_ff, fr_ff, rl_ff, rr_ff;
   logic                      timed_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rpm_ff    <= MAX_RPM_RESET;
         wdog_limit_ff <= WDOG_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MAX_RPM:    max_rpm_ff    <= csr_wdata[RPM_W-1:0];
            REG_WDOG_LIMIT: wdog_limit_ff <= csr_wdata[WDOG_W-1:0];
            default: ;
         endcase
      end
   end

   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s2_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   mmw_state #(.FRAC_BITS(FRAC_BITS)) u_state (
      .clock          (clock),
      .reset          (reset),
      .load           (req_fire),
      .cmd            (req_cmd),
      .vel_forward    (req_vel_forward),
      .vel_strafe     (req_vel_strafe),
      .vel_rotate     (req_vel_rotate),
      .system_ready   (req_system_ready),
      .manual_mode    (req_manual_mode),
      .watchdog_limit (wdog_limit_ff),
      .sum_fl         (sum_fl),
      .sum_fr         (sum_fr),
      .sum_rl         (sum_rl),
      .sum_rr         (sum_rr),
      .flags          (s1_flags)
   );

   mmw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_fl (
      .sum(sum_fl), .max_rpm(max_rpm_ff), .speed(fl));
   mmw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_fr (
      .sum(sum_fr), .max_rpm(max_rpm_ff), .speed(fr));
   mmw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_rl (
      .sum(sum_rl), .max_rpm(max_rpm_ff), .speed(rl));
   mmw_wheel #(.FRAC_BITS(FRAC_BITS)) u_wheel_rr (
      .sum(sum_rr), .max_rpm(max_rpm_ff), .speed(rr));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // not ready or watchdog trip forces all wheels to zero
   always_ff @(posedge clock) begin
      if (s2_load) begin
         fl_ff        <= s1_flags.zero_out ? '0 : fl;
         fr_ff        <= s1_flags.zero_out ? '0 : fr;
         rl_ff        <= s1_flags.zero_out ? '0 : rl;
         rr_ff        <= s1_flags.zero_out ? '0 : rr;
         timed_out_ff <= s1_flags.timed_out;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_front_left_speed  = fl_ff;
   assign rsp_front_right_speed = fr_ff;
   assign rsp_rear_left_speed   = rl_ff;
   assign rsp_rear_right_speed  = rr_ff;
   assign rsp_timed_out         = timed_out_ff;

   a_trip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && timed_out_ff |->
         (fl_ff == '0) && (fr_ff == '0) && (rl_ff == '0) && (rr_ff == '0))
      else $error("watchdog trip word carries nonzero wheel speed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |=> s1_valid_ff)
      else $error("stage 1 word dropped while output stalled");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input accepted with both stages full");

endmodule

FILE: sv/mmw_state.sv
// Command hold, idle watchdog and wheel mixing sums, with the first stage register.
// Depends on mmw_pkg.
module mmw_state import mmw_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           cmd,
   input  logic signed [VEL_W-1:0]        vel_forward,
   input  logic signed [VEL_W-1:0]        vel_strafe,
   input  logic signed [VEL_W-1:0]        vel_rotate,
   input  logic                           system_ready,
   input  logic                           manual_mode,
   input  logic        [WDOG_W-1:0]       watchdog_limit,
   output logic signed [FRAC_BITS+2:0]    sum_fl,
   output logic signed [FRAC_BITS+2:0]    sum_fr,
   output logic signed [FRAC_BITS+2:0]    sum_rl,
   output logic signed [FRAC_BITS+2:0]    sum_rr,
   output mmw_flags_type                  flags
);

   localparam int HW = FRAC_BITS + 2;
   localparam int SW = FRAC_BITS + 3;
   localparam logic signed [CLAMP_W-1:0] UNIT = CLAMP_W'(1) << FRAC_BITS;

   function automatic logic signed [HW-1:0] clamp_unit(input logic signed [VEL_W-1:0] v);
      logic signed [CLAMP_W-1:0] x;
      logic signed [CLAMP_W-1:0] y;
      x = {v[VEL_W-1], v};
      if (x > UNIT)
         y = UNIT;
      else if (x < -UNIT)
         y = -UNIT;
      else
         y = x;
      return y[HW-1:0];
   endfunction

   logic signed [HW-1:0]  held_fwd_ff, held_fwd_in;
   logic signed [HW-1:0]  held_str_ff, held_str_in;
   logic signed [HW-1:0]  held_rot_ff, held_rot_in;
   logic        [WDOG_W-1:0] idle_ff, idle_in;
   logic                  tripped_ff, tripped_in;
   logic                  fire;
   logic signed [SW-1:0]  f, s, r;
   logic signed [SW-1:0]  sum_fl_ff, sum_fr_ff, sum_rl_ff, sum_rr_ff;
   mmw_flags_type         flags_ff, flags_in;

   always_comb begin
      held_fwd_in = held_fwd_ff;
      held_str_in = held_str_ff;
      held_rot_in = held_rot_ff;
      tripped_in  = tripped_ff;
      fire        = 1'b0;
      if (!cmd) begin
         held_fwd_in = clamp_unit(vel_forward);
         held_str_in = clamp_unit(vel_strafe);
         held_rot_in = clamp_unit(vel_rotate);
         idle_in     = '0;
         tripped_in  = 1'b0;
      end else begin
         idle_in = (idle_ff == IDLE_SAT) ? idle_ff : idle_ff + WDOG_W'(1);
         fire    = manual_mode && !tripped_ff && (idle_in >= watchdog_limit);
         if (fire) begin
            held_fwd_in = '0;
            held_str_in = '0;
            held_rot_in = '0;
            tripped_in  = 1'b1;
         end
      end
      f = {held_fwd_in[HW-1], held_fwd_in};
      s = {held_str_in[HW-1], held_str_in};
      r = {held_rot_in[HW-1], held_rot_in};
      flags_in.zero_out  = !system_ready || fire;
      flags_in.timed_out = fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_fwd_ff <= '0;
         held_str_ff <= '0;
         held_rot_ff <= '0;
         idle_ff     <= '0;
         tripped_ff  <= 1'b0;
      end else if (load) begin
         held_fwd_ff <= held_fwd_in;
         held_str_ff <= held_str_in;
         held_rot_ff <= held_rot_in;
         idle_ff     <= idle_in;
         tripped_ff  <= tripped_in;
      end
   end

   // stage payload, qualified by the valid bit kept at the top level
   always_ff @(posedge clock) begin
      if (load) begin
         sum_fl_ff <= f - s - r;
         sum_fr_ff <= f + s + r;
         sum_rl_ff <= f + s - r;
         sum_rr_ff <= f - s + r;
         flags_ff  <= flags_in;
      end
   end

   assign sum_fl = sum_fl_ff;
   assign sum_fr = sum_fr_ff;
   assign sum_rl = sum_rl_ff;
   assign sum_rr = sum_rr_ff;
   assign flags  = flags_ff;

endmodule

FILE: sv/mmw_wheel.sv
// One wheel: scale a mixed sum by max_rpm, round half away from zero, clamp to +-max_rpm.
// Depends on mmw_pkg.
module mmw_wheel import mmw_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic signed [FRAC_BITS+2:0] sum,
   input  logic        [RPM_W-1:0]     max_rpm,
   output logic signed [SPEED_W-1:0]   speed
);

   localparam int SW = FRAC_BITS + 3;
   localparam int MW = SW + RPM_W;
   localparam int QW = MW - FRAC_BITS;

   logic              neg;
   logic [SW-1:0]     mag_in;
   logic [MW-1:0]     prod;
   logic [MW-1:0]     rnd;
   logic [QW-1:0]     q;
   logic [RPM_W-1:0]  mag_out;

   always_comb begin
      neg    = sum[SW-1];
      mag_in = neg ? SW'(-sum) : SW'(sum);
      prod   = MW'(mag_in) * MW'(max_rpm);
      rnd    = prod + (MW'(1) << (FRAC_BITS - 1));
      q      = rnd[MW-1:FRAC_BITS];
      if (q > QW'(max_rpm))
         mag_out = max_rpm;
      else
         mag_out = q[RPM_W-1:0];
      speed = neg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
   end

endmodule
